// ===== rtl/ods_pkg.sv =====
// ----------------------------------------------------------------------------
// ods_pkg
// Shared types and constants of the octave-down delay shifter.
// ----------------------------------------------------------------------------
package ods_pkg;

  // configuration register widths and reset values
  localparam int SIZE_W      = 4;
  localparam int FADE_W      = 8;
  localparam int CFG_W       = 8;
  localparam int CFG_INDEX_W = 1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;
  localparam logic [FADE_W-1:0] FADE_RESET = 8'd63;

  // legal range of the store size exponent
  localparam logic [SIZE_W-1:0] SIZE_MIN = 4'd8;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 4'd10;
  localparam int SIZE_MAX_I = 10;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_BITS   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FADE_LENGTH = 1'd1;

  // crossfade gain: unsigned q0.16 from a restoring divide
  localparam int GAIN_FRAC  = 16;
  localparam int DIV_NUM_W  = FADE_W + GAIN_FRAC;
  localparam int DIV_DEN_W  = FADE_W + 1;
  localparam int DIV_STEP_W = $clog2(DIV_NUM_W + 1);

  // handshake between the sequencer and the divider
  typedef struct packed {
    logic start;
    logic done;
  } div_ctrl_t;

endpackage

// ===== rtl/ods_ram.sv =====
// ----------------------------------------------------------------------------
// ods_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ods_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/ods_gain_div.sv =====
// ----------------------------------------------------------------------------
// ods_gain_div
// Restoring divider, one quotient bit per cycle, for the crossfade gain.
// ----------------------------------------------------------------------------
module ods_gain_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ods_pkg::DIV_NUM_W-1:0] numer,
  input  logic [ods_pkg::DIV_DEN_W-1:0] denom,
  output logic                          done,
  output logic [ods_pkg::DIV_NUM_W-1:0] quot
);

  logic                           busy;
  logic [ods_pkg::DIV_STEP_W-1:0] steps;
  logic [ods_pkg::DIV_NUM_W-1:0]  num_q;
  logic [ods_pkg::DIV_DEN_W-1:0]  rem;
  logic [ods_pkg::DIV_DEN_W-1:0]  den;
  logic [ods_pkg::DIV_DEN_W:0]    rem_shift;
  logic [ods_pkg::DIV_DEN_W:0]    diff;
  logic                           q_bit;

  // one trial subtraction per cycle
  always_comb begin
    rem_shift = {rem, num_q[ods_pkg::DIV_NUM_W-1]};
    diff      = rem_shift - {1'b0, den};
    q_bit     = (rem_shift >= {1'b0, den});
  end

  // step sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= ods_pkg::DIV_STEP_W'(ods_pkg::DIV_NUM_W);
      end else if (busy) begin
        steps <= steps - ods_pkg::DIV_STEP_W'(1);
        if (steps == ods_pkg::DIV_STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: the dividend register fills with quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      num_q <= numer;
      den   <= denom;
      rem   <= '0;
    end else if (busy) begin
      num_q <= {num_q[ods_pkg::DIV_NUM_W-2:0], q_bit};
      rem   <= q_bit ? diff[ods_pkg::DIV_DEN_W-1:0] : rem_shift[ods_pkg::DIV_DEN_W-1:0];
    end
  end

  assign quot = num_q;

endmodule

// ===== rtl/octave_down_delay_shifter_core.sv =====
// ----------------------------------------------------------------------------
// octave_down_delay_shifter_core
// Octave-down pitch shifter on a circular sample store with crossfade.
// ----------------------------------------------------------------------------
// Each input beat is written to the store at the write pointer and the output
// is the entry at the read pointer, which moves at half speed. During a
// crossfade the output blends toward the dry input with a q0.16 gain computed
// by a restoring divider. The result is registered through the READ, DIV
// (24 divider steps), MULT and DONE states, and DONE waits until the output
// is free, so out_stall can hold it; a new sample is taken only in IDLE. in_stall
// stays high while a sample is in work. A finished result sits in the output
// register while the next sample is taken. The store needs no clearing pass.
module octave_down_delay_shifter_core #(
  parameter int STORE_DEPTH  = 1024,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
  input  logic                                cfg_write,
  input  logic [ods_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ods_pkg::CFG_W-1:0]           cfg_data
);

  localparam int PW   = $clog2(STORE_DEPTH);
  localparam int DW   = SAMPLE_WIDTH + 1;
  localparam int GW   = ods_pkg::GAIN_FRAC + 1;
  localparam int PRW  = DW + GW;
  localparam int YW   = SAMPLE_WIDTH + 2;
  localparam int MW   = ods_pkg::SIZE_MAX_I + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MULT = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]                  state;
  logic [ods_pkg::SIZE_W-1:0]  size_bits;
  logic [ods_pkg::FADE_W-1:0]  fade_length;
  logic [PW-1:0]               write_pointer;
  logic [PW-1:0]               read_pointer;
  logic                        half_rate_toggle;
  logic [ods_pkg::FADE_W-1:0]  fade_count;

  logic [ods_pkg::SIZE_W-1:0]  size_clamped;
  logic [MW-1:0]               mask_full;
  logic [PW-1:0]               ptr_mask;
  logic [PW-1:0]               w_cur;
  logic [PW-1:0]               r_cur;
  logic [PW-1:0]               w_next;
  logic [PW-1:0]               r_next;
  logic                        accept;
  logic                        fading;
  logic [ods_pkg::FADE_W-1:0]  gain_count;

  logic                        item_fading;
  logic [PW-1:0]               item_raddr;
  logic signed [SAMPLE_WIDTH-1:0] item_x;
  logic [SAMPLE_WIDTH-1:0]     ram_rdata;

  ods_pkg::div_ctrl_t          div_ctrl;
  logic                        div_done;
  logic [ods_pkg::DIV_NUM_W-1:0] div_quot;
  logic [ods_pkg::GAIN_FRAC-1:0] gain;

  logic signed [DW-1:0]        diff;
  logic signed [PRW-1:0]       prod;
  logic signed [YW-1:0]        y_fade;
  logic signed [YW-1:0]        y_sel;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic signed [YW-1:0]        y_max;
  logic signed [YW-1:0]        y_min;
  logic                        out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_bits   <= ods_pkg::SIZE_RESET;
      fade_length <= ods_pkg::FADE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ods_pkg::REG_SIZE_BITS:   size_bits   <= cfg_data[ods_pkg::SIZE_W-1:0];
        ods_pkg::REG_FADE_LENGTH: fade_length <= cfg_data[ods_pkg::FADE_W-1:0];
        default: ;
      endcase
    end
  end

  // active pointer mask
  always_comb begin
    if (size_bits < ods_pkg::SIZE_MIN) begin
      size_clamped = ods_pkg::SIZE_MIN;
    end else if (size_bits > ods_pkg::SIZE_MAX) begin
      size_clamped = ods_pkg::SIZE_MAX;
    end else begin
      size_clamped = size_bits;
    end
    mask_full = (MW'(1) << size_clamped) - MW'(1);
    ptr_mask  = PW'(mask_full) & PW'(STORE_DEPTH - 1);
  end

  // pointer advance and collision test
  always_comb begin
    accept     = in_valid && !in_stall;
    fading     = (fade_count != '0);
    w_cur      = write_pointer & ptr_mask;
    r_cur      = read_pointer & ptr_mask;
    r_next     = (r_cur + PW'(half_rate_toggle)) & ptr_mask;
    w_next     = (w_cur + PW'(1)) & ptr_mask;
    gain_count = (fade_count > fade_length) ? fade_length : fade_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer    <= '0;
      read_pointer     <= '0;
      half_rate_toggle <= 1'b0;
      fade_count       <= '0;
    end else if (accept) begin
      write_pointer    <= w_next;
      read_pointer     <= r_next;
      half_rate_toggle <= !half_rate_toggle;
      if (fading) begin
        fade_count <= fade_count - ods_pkg::FADE_W'(1);
      end else if (((w_next + PW'(fade_length)) & ptr_mask) == r_next) begin
        fade_count <= fade_length;
      end
    end
  end

  // per-sample working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_x      <= sample_in;
      item_raddr  <= r_cur;
      item_fading <= fading;
    end
  end

  // sample store, written on accept and read in the following cycle
  ods_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (w_cur),
    .wr_data (sample_in),
    .rd_en   (state == ST_READ),
    .rd_addr (item_raddr),
    .rd_data (ram_rdata)
  );

  // crossfade gain divider
  assign div_ctrl = '{start: accept, done: div_done};

  ods_gain_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_ctrl.start),
    .numer ({gain_count, ods_pkg::GAIN_FRAC'(0)}),
    .denom ({1'b0, fade_length} + ods_pkg::DIV_DEN_W'(1)),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign gain = div_quot[ods_pkg::GAIN_FRAC-1:0];

  // gain times wet minus dry, registered
  assign diff = DW'($signed(ram_rdata)) - DW'(item_x);

  always_ff @(posedge clk) begin
    if (state == ST_MULT) begin
      prod <= PRW'($signed({1'b0, gain})) * PRW'(diff);
    end
  end

  // blend, select and saturate
  always_comb begin
    y_fade = YW'(item_x) + prod[PRW-1:ods_pkg::GAIN_FRAC];
    y_sel  = item_fading ? y_fade : YW'($signed(ram_rdata));
    y_max  = YW'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
    y_min  = -y_max - YW'(1);
    if (y_sel > y_max) begin
      y_sat = y_max[SAMPLE_WIDTH-1:0];
    end else if (y_sel < y_min) begin
      y_sat = y_min[SAMPLE_WIDTH-1:0];
    end else begin
      y_sat = y_sel[SAMPLE_WIDTH-1:0];
    end
  end

  // sequencer
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (accept) state <= ST_READ;
        ST_READ: state <= ST_DIV;
        ST_DIV:  if (div_ctrl.done) state <= ST_MULT;
        ST_MULT: state <= ST_DONE;
        ST_DONE: if (out_free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      sample_out <= y_sat;
    end
  end

`ifndef NO_ASSERTIONS
  // the divider finishes only while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_ctrl.done |-> (state == ST_DIV))
    else $error("divider done outside its wait state");

  // the gain is always below one
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    div_ctrl.done |=> (div_quot[ods_pkg::DIV_NUM_W-1:ods_pkg::GAIN_FRAC] == '0))
    else $error("crossfade gain reached one");

  // fade state and pointers move only on an accepted beat
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    (!accept && !$past(rst)) |=> ($stable(fade_count) && $stable(write_pointer)))
    else $error("sample state changed without an input beat");

  // a result is loaded only from the final sequencer state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (!out_valid ##1 out_valid) |-> ($past(state) == ST_DONE))
    else $error("result appeared without a finished sample");
`endif

endmodule
